>>> rtl/tpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpe_pkg: shared types and constants for the PTWRITE payload extractor
// Packet codes, the parser phase type and the queue entry passed from the
// classifying front end to the payload assembler.
// ----------------------------------------------------------------------------
package tpe_pkg;

	localparam logic [7:0] EXT_ESC     = 8'h02;  // announces an extended opcode
	localparam logic [7:0] EXT_SKIP1   = 8'h03;  // extended opcode with one trailing byte
	localparam logic [4:0] PTW_OPC_LOW = 5'h12;  // low five bits of a PTWRITE opcode

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned PAYLOAD_W = 64;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_EXTOP,
		PH_SKIP,
		PH_PAYLOAD
	} tpe_phase_t;

	// One payload byte with its position in the payload.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
		logic              last;
		logic              wide;
	} tpe_cmd_t;

endpackage

>>> rtl/tpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpe_front: packet parser
// Walks the trace byte stream, recognises PTWRITE packets and hands each
// payload byte, tagged with its position, to the queue.
// ----------------------------------------------------------------------------
module tpe_front import tpe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [BYTE_W-1:0]   in_byte,
	output logic                in_ready,
	input  logic                q_full,
	output logic                push,
	output tpe_cmd_t            push_cmd
);

	tpe_phase_t       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             wide_q, wide_d;
	logic             take;
	logic             last_byte;

	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;
	assign last_byte = wide_q ? (idx_q == IDX_W'(7)) : (idx_q == IDX_W'(3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			idx_q   <= '0;
			wide_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			wide_q  <= wide_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		wide_d        = wide_q;
		push          = 1'b0;
		push_cmd.data = in_byte;
		push_cmd.idx  = idx_q;
		push_cmd.last = last_byte;
		push_cmd.wide = wide_q;
		if (take) begin
			unique case (state_q)
				PH_IDLE: begin
					if (in_byte == EXT_ESC) begin
						state_d = PH_EXTOP;
					end
				end
				PH_EXTOP: begin
					if (in_byte[4:0] == PTW_OPC_LOW) begin
						wide_d  = |in_byte[6:5];
						idx_d   = '0;
						state_d = PH_PAYLOAD;
					end else if (in_byte == EXT_SKIP1) begin
						state_d = PH_SKIP;
					end else begin
						state_d = PH_IDLE;
					end
				end
				PH_SKIP: begin
					state_d = PH_IDLE;
				end
				PH_PAYLOAD: begin
					push  = 1'b1;
					idx_d = idx_q + 1'b1;
					if (last_byte) begin
						state_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	// Payload bytes are only queued while inside a PTWRITE packet.
	a_push_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> state_q == PH_PAYLOAD)
		else $error("payload byte queued outside a PTWRITE packet");

	a_last_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_cmd.last |=> state_q == PH_IDLE)
		else $error("parser did not return to idle after the last payload byte");

	a_narrow_idx: assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_cmd.wide |-> !push_cmd.idx[2])
		else $error("four-byte payload index out of range");

endmodule

>>> rtl/tpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpe_queue: command queue
// Small first-in first-out store of payload byte commands between the
// parser and the assembler.
// ----------------------------------------------------------------------------
module tpe_queue import tpe_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tpe_cmd_t push_cmd,
	output logic     full,
	output logic     head_valid,
	output tpe_cmd_t head_cmd,
	input  logic     pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tpe_cmd_t         entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond its depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("word pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("word popped from an empty queue");

endmodule

>>> rtl/tpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpe_back: payload assembler
// Merges queued payload bytes little-endian into the accumulator and loads
// the finished payload into the output register.
// ----------------------------------------------------------------------------
module tpe_back import tpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tpe_cmd_t             head_cmd,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PAYLOAD_W-1:0] out_value,
	output logic                 out_wide
);

	logic [PAYLOAD_W-1:0] acc_q;
	logic [PAYLOAD_W-1:0] acc_next;
	logic [PAYLOAD_W-1:0] byte_shifted;
	logic                 out_valid_q;
	logic [PAYLOAD_W-1:0] out_value_q;
	logic                 out_wide_q;
	logic                 out_free;

	assign out_free     = !out_valid_q || out_ready;
	assign pop          = head_valid && (!head_cmd.last || out_free);
	assign byte_shifted = {{(PAYLOAD_W - BYTE_W){1'b0}}, head_cmd.data}
		<< {head_cmd.idx, 3'b000};
	// The first byte of a payload starts a fresh accumulator.
	assign acc_next     = ((head_cmd.idx == '0) ? '0 : acc_q) | byte_shifted;

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= acc_next;
		end
		if (pop && head_cmd.last) begin
			out_value_q <= acc_next;
			out_wide_q  <= head_cmd.wide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head_cmd.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_wide  = out_wide_q;

	a_word_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && head_cmd.last))
		else $error("output word appeared without a completed payload");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_wide_q |-> out_value_q[63:32] == '0)
		else $error("four-byte payload has upper bits set");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=>
			out_valid_q && $stable(out_value_q) && $stable(out_wide_q))
		else $error("output word changed while the receiver stalled");

endmodule

>>> rtl/trace_ptwrite_payload_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_ptwrite_payload_extractor: PTWRITE payload extractor
// Parses a processor trace byte stream and delivers every PTWRITE payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one trace byte per word in s_tdata[7:0].
//   Output channel m_*: one word per PTWRITE packet; m_tdata carries the
//   payload (zero-extended for four-byte packets), m_tuser[0] is set when
//   the packet carried eight bytes.
//   The parser takes one byte per cycle while the queue is not full.
//   Payload bytes pass through a command queue of QUEUE_DEPTH entries
//   to the assembler, which also merges one byte per cycle unless a
//   last byte waits for a held output word. Each byte is registered in the
//   queue, and the payload in the output register, before m_tvalid rises.
//   Reset returns the parser to idle, empties the queue and drops any
//   pending output word. When the receiver stalls, the output register
//   holds its word; the assembler keeps merging bytes of the next payload
//   and stops only at that payload's last byte, after which the queue
//   fills and s_tready falls.
// ----------------------------------------------------------------------------
module trace_ptwrite_payload_extractor import tpe_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] trace_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] payload_value
	output logic [0:0]  m_tuser    // [0] payload_wide
);

	logic     q_full;
	logic     push;
	tpe_cmd_t push_cmd;
	logic     head_valid;
	tpe_cmd_t head_cmd;
	logic     pop;

	tpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_ready (s_tready),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	tpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_wide   (m_tuser[0])
	);

endmodule
